/* design/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants of the matrix to quaternion converter
// Data widths, saturation limits, branch codes and the word carried down
// the square root pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W = 18;   // width of every matrix and quaternion field
  localparam int MAG_W  = 19;   // magnitude of a sum or difference of two fields
  localparam int QMAX   = 131071;
  localparam int QMIN   = -131072;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  // branch and the numerators of the three divided components, sign and magnitude
  typedef struct packed {
    branch_e                 branch;
    logic [2:0]              neg;
    logic [2:0][MAG_W-1:0]   mag;
  } carry_t;

endpackage

/* design/rmq_if.sv */
// ----------------------------------------------------------------------------
// rmq_if: valid/ready channels of the matrix to quaternion converter
// Input channel carries the nine rotation entries, output the quaternion.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::DATA_W-1:0]   elem0;
  logic signed [rmq_pkg::DATA_W-1:0]   elem1;
  logic signed [rmq_pkg::DATA_W-1:0]   elem2;
  logic signed [rmq_pkg::DATA_W-1:0]   elem4;
  logic signed [rmq_pkg::DATA_W-1:0]   elem5;
  logic signed [rmq_pkg::DATA_W-1:0]   elem6;
  logic signed [rmq_pkg::DATA_W-1:0]   elem8;
  logic signed [rmq_pkg::DATA_W-1:0]   elem9;
  logic signed [rmq_pkg::DATA_W-1:0]   elem10;

  modport source (
    output valid, elem0, elem1, elem2, elem4, elem5, elem6, elem8, elem9, elem10,
    input  ready
  );
  modport sink (
    input  valid, elem0, elem1, elem2, elem4, elem5, elem6, elem8, elem9, elem10,
    output ready
  );
endinterface

interface rmq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::DATA_W-1:0]   quat_w;
  logic signed [rmq_pkg::DATA_W-1:0]   quat_x;
  logic signed [rmq_pkg::DATA_W-1:0]   quat_y;
  logic signed [rmq_pkg::DATA_W-1:0]   quat_z;
  logic [1:0]                          branch_taken;
  logic                                degenerate;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, branch_taken, degenerate,
    output ready
  );
endinterface

/* design/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: pipelined rotation matrix to quaternion
// Trace or largest-diagonal conversion with a bit-per-stage square root and
// three bit-per-stage dividers; degenerate inputs saturate and are flagged.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one word per matrix: the nine rotation entries in signed
//   fixed point with FRAC_BITS fraction bits. out_o returns one word per
//   matrix: quaternion w, x, y, z, the branch used and a degenerate flag.
//   both channels take a word when valid and ready are high at a clock edge
// pipeline and throughput:
//   the pipeline depth is set by the square root, one root bit per stage
//   for a root of QW bits, and the dividers, one quotient bit per stage
//   for 18 bits
//   one word is accepted every cycle while the receiver keeps up
// reset:
//   rst_ni clears every stage valid bit at once; data registers keep garbage
// stall:
//   when the output word waits and out_o.ready is low, the whole pipeline
//   freezes and in_i.ready drops in the same cycle; nothing is lost
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  localparam int DW  = rmq_pkg::DATA_W;
  localparam int MW  = rmq_pkg::MAG_W;
  localparam int QB  = DW;                                      // quotient bits
  localparam int TW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3; // trace width
  localparam int RW  = TW + FRAC_BITS;                          // radicand width
  localparam int QW  = (RW + 1) / 2;                            // root width
  localparam int EW  = RW + 1;                                  // sqrt remainder
  localparam int DNW = QW + 1;                                  // divisor width
  localparam int NW  = MW + FRAC_BITS;                          // dividend width
  localparam int XW  = ((NW > DNW + QB) ? NW : DNW + QB) + 1;   // div remainder
  localparam int CW  = ((QW > DW) ? QW : DW) + 1;
  localparam int ThrI = (1 << FRAC_BITS) / 10000;

  localparam logic signed [TW-1:0] OneC = TW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] ThrC = TW'(ThrI);
  localparam logic signed [DW-1:0] MaxC = DW'(rmq_pkg::QMAX);
  localparam logic signed [DW-1:0] MinC = DW'(rmq_pkg::QMIN);

  // global advance: everything moves unless the output word is stuck
  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: trace, branch pick, radicand and numerators
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] m00, m11, m22, t_s, d_s;
  logic [TW-1:0]        rv;
  logic [RW-1:0]        rad_d;
  logic signed [MW-1:0] n_a, n_b, n_c, n_p, n_q, n_r;
  logic signed [MW-1:0] nsel [3];
  rmq_pkg::branch_e     br_d;
  rmq_pkg::carry_t      car_d;

  always_comb begin
    m00 = TW'(in_i.elem0);
    m11 = TW'(in_i.elem5);
    m22 = TW'(in_i.elem10);
    t_s = m00 + m11 + m22 + OneC;
    // differences and sums of the off-diagonal entries
    n_a = MW'(in_i.elem6) - MW'(in_i.elem9);   // m21 - m12
    n_b = MW'(in_i.elem8) - MW'(in_i.elem2);   // m02 - m20
    n_c = MW'(in_i.elem1) - MW'(in_i.elem4);   // m10 - m01
    n_p = MW'(in_i.elem4) + MW'(in_i.elem1);   // m01 + m10
    n_q = MW'(in_i.elem8) + MW'(in_i.elem2);   // m02 + m20
    n_r = MW'(in_i.elem9) + MW'(in_i.elem6);   // m12 + m21
    if (t_s > ThrC) begin
      br_d = rmq_pkg::BR_TRACE;
      d_s  = t_s;
    end else if (m00 > m11 && m00 > m22) begin
      br_d = rmq_pkg::BR_X;
      d_s  = OneC + m00 - m11 - m22;
    end else if (m11 > m22) begin
      br_d = rmq_pkg::BR_Y;
      d_s  = OneC + m11 - m00 - m22;
    end else begin
      br_d = rmq_pkg::BR_Z;
      d_s  = OneC + m22 - m00 - m11;
    end
    // a negative radicand becomes zero, which the root check flags later
    rv    = d_s[TW-1] ? '0 : d_s;
    rad_d = RW'(rv) << FRAC_BITS;
    case (br_d)
      rmq_pkg::BR_TRACE: begin nsel[0] = n_a; nsel[1] = n_b; nsel[2] = n_c; end
      rmq_pkg::BR_X:     begin nsel[0] = n_a; nsel[1] = n_p; nsel[2] = n_q; end
      rmq_pkg::BR_Y:     begin nsel[0] = n_b; nsel[1] = n_p; nsel[2] = n_r; end
      rmq_pkg::BR_Z:     begin nsel[0] = n_c; nsel[1] = n_q; nsel[2] = n_r; end
      default:           begin nsel[0] = n_a; nsel[1] = n_b; nsel[2] = n_c; end
    endcase
    car_d.branch = br_d;
    for (int i = 0; i < 3; i++) begin
      car_d.neg[i] = nsel[i][MW-1];
      car_d.mag[i] = nsel[i][MW-1] ? MW'(-nsel[i]) : MW'(nsel[i]);
    end
  end

  // --------------------------------------------------------------------------
  // square root, one root bit per stage, remainder kept as rad - root^2
  // --------------------------------------------------------------------------
  logic            sq_vld_q  [QW+1];
  logic [EW-1:0]   sq_rem_q  [QW+1];
  logic [QW-1:0]   sq_root_q [QW+1];
  rmq_pkg::carry_t sq_car_q  [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= EW'(rad_d);
      sq_root_q[0] <= '0;
      sq_car_q[0]  <= car_d;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_sqrt
    localparam int B = QW - 1 - j;
    logic [EW-1:0] trial;
    logic          take;

    assign trial = (EW'(sq_root_q[j]) << (B + 1)) + (EW'(1) << (2 * B));
    assign take  = sq_rem_q[j] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j+1] <= sq_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[j+1]  <= take ? sq_rem_q[j] - trial : sq_rem_q[j];
        sq_root_q[j+1] <= take ? (sq_root_q[j] | (QW'(1) << B)) : sq_root_q[j];
        sq_car_q[j+1]  <= sq_car_q[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // divider setup: divisor 2*root, own component root/2, overflow check
  // --------------------------------------------------------------------------
  logic             dv_vld_q [QB+1];
  logic [DNW-1:0]   dv_den_q [QB+1];
  logic [QW-1:0]    dv_own_q [QB+1];
  logic             dv_dgn_q [QB+1];
  rmq_pkg::branch_e dv_br_q  [QB+1];
  logic [2:0]       dv_neg_q [QB+1];
  logic [2:0]       dv_ovf_q [QB+1];
  logic [XW-1:0]    dv_rem_q [QB+1][3];
  logic [QB-1:0]    dv_quo_q [QB+1][3];

  logic [DNW-1:0]   den0;
  logic [XW-1:0]    num0 [3];
  logic [2:0]       ovf0;

  always_comb begin
    den0 = {sq_root_q[QW], 1'b0};
    for (int i = 0; i < 3; i++) begin
      num0[i] = XW'(sq_car_q[QW].mag[i]) << FRAC_BITS;
      // quotient would not fit in the output width
      ovf0[i] = num0[i] >= (XW'(den0) << QB);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= sq_vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_den_q[0] <= den0;
      dv_own_q[0] <= sq_root_q[QW] >> 1;
      dv_dgn_q[0] <= sq_root_q[QW] == '0;
      dv_br_q[0]  <= sq_car_q[QW].branch;
      dv_neg_q[0] <= sq_car_q[QW].neg;
      dv_ovf_q[0] <= ovf0;
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= num0[i];
        dv_quo_q[0][i] <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic [XW-1:0] trial;

    assign trial = XW'(dv_den_q[j]) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_den_q[j+1] <= dv_den_q[j];
        dv_own_q[j+1] <= dv_own_q[j];
        dv_dgn_q[j+1] <= dv_dgn_q[j];
        dv_br_q[j+1]  <= dv_br_q[j];
        dv_neg_q[j+1] <= dv_neg_q[j];
        dv_ovf_q[j+1] <= dv_ovf_q[j];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic take;
      assign take = dv_rem_q[j][i] >= trial;

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[j+1][i] <= take ? dv_rem_q[j][i] - trial : dv_rem_q[j][i];
          dv_quo_q[j+1][i] <= take ? (dv_quo_q[j][i] | (QB'(1) << K)) : dv_quo_q[j][i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output: place components by branch, saturate, register
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] own_sat;
  logic signed [DW-1:0] lane_sat [3];
  logic signed [DW-1:0] quat_d   [4];
  logic signed [DW-1:0] quat_q   [4];
  rmq_pkg::branch_e     br_q;
  logic                 dgn_q;

  always_comb begin
    logic [1:0] own_idx;
    logic [1:0] slot;
    own_idx = dv_br_q[QB];
    own_sat = (CW'(dv_own_q[QB]) > CW'(rmq_pkg::QMAX)) ? MaxC : DW'(dv_own_q[QB]);
    for (int i = 0; i < 3; i++) begin
      if (dv_neg_q[QB][i]) begin
        lane_sat[i] = (dv_ovf_q[QB][i] || dv_quo_q[QB][i] > QB'(131072)) ?
                      MinC : DW'(-dv_quo_q[QB][i]);
      end else begin
        lane_sat[i] = (dv_ovf_q[QB][i] || dv_quo_q[QB][i] > QB'(131071)) ?
                      MaxC : DW'(dv_quo_q[QB][i]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      slot = (2'(c) < own_idx) ? 2'(c) : 2'(c - 1);
      if (dv_dgn_q[QB]) begin
        quat_d[c] = MaxC;
      end else if (2'(c) == own_idx) begin
        quat_d[c] = own_sat;
      end else begin
        quat_d[c] = lane_sat[slot];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= quat_d;
      br_q   <= dv_br_q[QB];
      dgn_q  <= dv_dgn_q[QB];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.quat_w       = quat_q[0];
  assign out_o.quat_x       = quat_q[1];
  assign out_o.quat_y       = quat_q[2];
  assign out_o.quat_z       = quat_q[3];
  assign out_o.branch_taken = br_q;
  assign out_o.degenerate   = dgn_q;

`ifndef SYNTH
  // the trace formula always has a root of at least one
  a_trace_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.branch_taken == rmq_pkg::BR_TRACE |-> !out_o.degenerate)
    else $error("trace branch flagged degenerate");

  // a degenerate word carries the saturated quaternion in every component
  a_degen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.quat_w == MaxC && out_o.quat_x == MaxC &&
      out_o.quat_y == MaxC && out_o.quat_z == MaxC)
    else $error("degenerate word not saturated");

  // in the X branch the component from the root, quat_x, is never negative
  a_own_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.branch_taken == rmq_pkg::BR_X |-> !out_o.quat_x[DW-1])
    else $error("root component negative");
`endif

endmodule
